// ----- rtl/core/ppi_pkg.sv -----
// Package for the polar path interpolator: item and state types, fixed-point constants
// and the CORDIC arctangent table.
// It has no dependencies. Every module of the block imports it.
package ppi_pkg;

    localparam int TDATA_IN_W  = 56;
    localparam int TDATA_OUT_W = 48;
    localparam int CFG_W       = 10;
    localparam int POS_W       = 21;
    localparam int RHOC_W      = 17;

    localparam logic [20:0]        ONE_Q20     = 21'h100000;
    localparam logic [16:0]        RHO_MAX     = 17'h10000;
    localparam logic [31:0]        PHASE_K     = 32'd683565276;
    localparam logic [31:0]        RAD_K       = 32'd1686629713;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [63:0]        RND20       = 64'd524288;
    localparam logic [63:0]        RND30       = 64'd536870912;
    localparam logic [POS_W-1:0]   POS_MAX     = {POS_W{1'b1}};

    typedef enum logic {
        KIND_WAYPOINT = 1'b0,
        KIND_STEP     = 1'b1
    } ppi_kind_t;

    typedef struct packed {
        ppi_kind_t          kind;
        logic signed [31:0] theta;
        logic [RHOC_W-1:0]  rho;
    } ppi_item_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_WAYPT,
        ST_PROD,
        ST_DIVR_SET,
        ST_DIVR,
        ST_DIVA_SET,
        ST_DIVA,
        ST_FIX,
        ST_MOV_A,
        ST_MOV_R,
        ST_MOV_FIN,
        ST_PH1,
        ST_PH2,
        ST_PH3,
        ST_CR_INIT,
        ST_CR,
        ST_ROT,
        ST_OUT_X,
        ST_OUT_Y,
        ST_OUT_W,
        ST_SEND
    } ppi_state_t;

    function automatic logic [31:0] atan_q30(input logic [4:0] idx);
        logic [31:0] val;
        case (idx)
            5'd0:    val = 32'd843314857;
            5'd1:    val = 32'd497837829;
            5'd2:    val = 32'd263043837;
            5'd3:    val = 32'd133525159;
            5'd4:    val = 32'd67021687;
            5'd5:    val = 32'd33543516;
            5'd6:    val = 32'd16775851;
            5'd7:    val = 32'd8388437;
            5'd8:    val = 32'd4194283;
            5'd9:    val = 32'd2097149;
            5'd31:   val = 32'd0;
            default: val = 32'd1 << (5'd30 - idx);
        endcase
        return val;
    endfunction

endpackage

// ----- rtl/core/ppi_front.sv -----
// Front end of the polar path interpolator: accepts input words, classifies them
// and clamps rho, then holds them in a four-entry queue for the back end. Uses ppi_pkg.
module ppi_front
    import ppi_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [TDATA_IN_W-1:0] s_axis_tdata,  // theta[31:0], rho[49:32], zero fill
    input  logic                  s_axis_tuser,  // mode
    input  logic                  pop,
    output ppi_item_t             head,
    output logic                  head_valid
);

    localparam int QD = 4;
    localparam int PW = $clog2(QD);

    ppi_item_t         mem [QD];
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW:0]       count_reg, count_next;
    logic              push;
    logic signed [17:0] rho_in;
    ppi_item_t         item_in;

    assign s_axis_tready = (count_reg != (PW+1)'(QD));
    assign push          = s_axis_tvalid && s_axis_tready;
    assign head_valid    = (count_reg != '0);
    assign head          = mem[rd_ptr_reg];

    always_comb
    begin
        rho_in        = signed'(s_axis_tdata[49:32]);
        item_in.kind  = s_axis_tuser ? KIND_STEP : KIND_WAYPOINT;
        item_in.theta = signed'(s_axis_tdata[31:0]);
        if (rho_in < 0)
        begin
            item_in.rho = '0;
        end
        else if (rho_in > signed'({1'b0, RHO_MAX}))
        begin
            item_in.rho = RHO_MAX;
        end
        else
        begin
            item_in.rho = rho_in[RHOC_W-1:0];
        end

        rd_ptr_next = rd_ptr_reg + PW'(pop);
        wr_ptr_next = wr_ptr_reg + PW'(push);
        count_next  = count_reg + (PW+1)'(push) - (PW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= item_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/core/ppi_back.sv -----
// Back end of the polar path interpolator: sequencer with one shared multiplier,
// a restoring divider and an iterative CORDIC rotation. Uses ppi_pkg.
module ppi_back
    import ppi_pkg::*;
#(
    parameter int CORDIC_STEPS = 20,
    parameter int RADIUS_BITS  = 10
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [RADIUS_BITS-1:0] radius,
    input  ppi_item_t              head,
    input  logic                   head_valid,
    output logic                   pop,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [TDATA_OUT_W-1:0] m_axis_tdata,  // x_pos[20:0], y_pos[41:21], zero fill
    output logic                   m_axis_tlast   // segment_last
);

    localparam int RW = RADIUS_BITS + 10;
    localparam int DW = RW + 33;
    localparam int CW = $clog2(CORDIC_STEPS + 1);

    ppi_state_t          state_reg, state_next;
    logic signed [31:0]  theta_reg, theta_next;
    logic signed [31:0]  cur_angle_reg, cur_angle_next;
    logic [RW-1:0]       cur_radius_reg, cur_radius_next;
    logic signed [32:0]  dangle_reg, dangle_next;
    logic signed [RW:0]  dradius_reg, dradius_next;
    logic [20:0]         progress_reg, progress_next;
    logic                have_pos_reg, have_pos_next;
    logic                seg_open_reg, seg_open_next;
    logic [63:0]         prod_reg, prod_next;
    logic [DW-1:0]       p_reg, p_next;
    logic [DW-1:0]       rem_reg, rem_next;
    logic [DW-1:0]       den_reg, den_next;
    logic [19:0]         quo_reg, quo_next;
    logic [4:0]          dcnt_reg, dcnt_next;
    logic [20:0]         f_reg, f_next;
    logic                last_reg, last_next;
    logic [31:0]         phase_reg, phase_next;
    logic signed [33:0]  cx_reg, cx_next;
    logic signed [33:0]  cy_reg, cy_next;
    logic signed [33:0]  cz_reg, cz_next;
    logic [CW-1:0]       ccnt_reg, ccnt_next;
    logic signed [33:0]  cos_reg, cos_next;
    logic signed [33:0]  sin_reg, sin_next;
    logic [POS_W-1:0]    xo_reg, xo_next;
    logic [POS_W-1:0]    yo_reg, yo_next;
    logic                out_valid_reg, out_valid_next;
    logic [POS_W-1:0]    out_x_reg, out_x_next;
    logic [POS_W-1:0]    out_y_reg, out_y_next;
    logic                out_last_reg, out_last_next;

    logic [31:0]         op_a;
    logic [31:0]         op_b;
    logic [31:0]         da_abs;
    logic [RW-1:0]       dr_abs;
    logic [32:0]         dangle_mag;
    logic [RW:0]         dradius_mag;
    logic [DW-1:0]       rem2;
    logic                div_ge;
    logic [DW-1:0]       rem_step;
    logic [19:0]         quo_step;
    logic [20:0]         f_min;
    logic [20:0]         f_nz;
    logic [21:0]         prog_sum;
    logic [32:0]         amag;
    logic [RW:0]         rmag;
    logic signed [RW+1:0] rsum;
    logic [21:0]         prog_new;
    logic [RW-1:0]       r_wp;
    logic signed [33:0]  shx;
    logic signed [33:0]  shy;
    logic signed [33:0]  at_ext;
    logic [33:0]         cos_mag;
    logic [33:0]         sin_mag;

    function automatic logic [POS_W-1:0] place(input logic neg, input logic [63:0] p,
                                               input logic [RADIUS_BITS-1:0] rad);
        logic signed [39:0] base;
        logic signed [39:0] mag;
        logic signed [39:0] sum;
        logic [POS_W-1:0]   res;
        base = signed'(40'({rad, 10'b0}));
        mag  = signed'(40'((p + RND30) >> 30));
        sum  = neg ? (base - mag) : (base + mag);
        if (sum < 0)
        begin
            res = '0;
        end
        else if (sum > signed'(40'(POS_MAX)))
        begin
            res = POS_MAX;
        end
        else
        begin
            res = sum[POS_W-1:0];
        end
        return res;
    endfunction

    assign dangle_mag  = dangle_reg[32] ? 33'(-dangle_reg) : 33'(dangle_reg);
    assign dradius_mag = dradius_reg[RW] ? (RW+1)'(-dradius_reg) : (RW+1)'(dradius_reg);
    assign da_abs      = dangle_mag[31:0];
    assign dr_abs      = dradius_mag[RW-1:0];
    assign cos_mag     = cos_reg[33] ? 34'(-cos_reg) : 34'(cos_reg);
    assign sin_mag     = sin_reg[33] ? 34'(-sin_reg) : 34'(sin_reg);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(TDATA_OUT_W - 2*POS_W){1'b0}}, out_y_reg, out_x_reg};
    assign m_axis_tlast  = out_last_reg;

    always_comb
    begin
        case (state_reg)
            ST_IDLE:
            begin
                op_a = 32'(head.rho);
                op_b = 32'(radius);
            end
            ST_PROD:
            begin
                op_a = da_abs;
                op_b = 32'(cur_radius_reg);
            end
            ST_MOV_A:
            begin
                op_a = da_abs;
                op_b = 32'(f_reg);
            end
            ST_MOV_R:
            begin
                op_a = 32'(dr_abs);
                op_b = 32'(f_reg);
            end
            ST_PH1:
            begin
                op_a = cur_angle_reg;
                op_b = PHASE_K;
            end
            ST_PH3:
            begin
                op_a = {2'b0, phase_reg[29:0]};
                op_b = RAD_K;
            end
            ST_OUT_X:
            begin
                op_a = cos_mag[31:0];
                op_b = 32'(cur_radius_reg);
            end
            ST_OUT_Y:
            begin
                op_a = sin_mag[31:0];
                op_b = 32'(cur_radius_reg);
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
        prod_next = op_a * op_b;
    end

    always_comb
    begin
        state_next      = state_reg;
        theta_next      = theta_reg;
        cur_angle_next  = cur_angle_reg;
        cur_radius_next = cur_radius_reg;
        dangle_next     = dangle_reg;
        dradius_next    = dradius_reg;
        progress_next   = progress_reg;
        have_pos_next   = have_pos_reg;
        seg_open_next   = seg_open_reg;
        p_next          = p_reg;
        rem_next        = rem_reg;
        den_next        = den_reg;
        quo_next        = quo_reg;
        dcnt_next       = dcnt_reg;
        f_next          = f_reg;
        last_next       = last_reg;
        phase_next      = phase_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        cz_next         = cz_reg;
        ccnt_next       = ccnt_reg;
        cos_next        = cos_reg;
        sin_next        = sin_reg;
        xo_next         = xo_reg;
        yo_next         = yo_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;
        out_last_next   = out_last_reg;
        pop             = 1'b0;

        rem2     = {rem_reg[DW-2:0], 1'b0};
        div_ge   = (rem2 >= den_reg);
        rem_step = div_ge ? (rem2 - den_reg) : rem2;
        quo_step = {quo_reg[18:0], div_ge};
        f_min    = ({1'b0, quo_step} < f_reg) ? {1'b0, quo_step} : f_reg;
        f_nz     = (f_reg == '0) ? 21'd1 : f_reg;
        prog_sum = {1'b0, progress_reg} + {1'b0, f_nz};
        amag     = 33'((prod_reg + RND20) >> 20);
        rmag     = (RW+1)'((prod_reg + RND20) >> 20);
        rsum     = dradius_reg[RW] ? (signed'({2'b0, cur_radius_reg}) - signed'({1'b0, rmag}))
                                   : (signed'({2'b0, cur_radius_reg}) + signed'({1'b0, rmag}));
        prog_new = {1'b0, progress_reg} + {1'b0, f_reg};
        r_wp     = prod_reg[RW+5:6];
        shx      = cy_reg >>> ccnt_reg;
        shy      = cx_reg >>> ccnt_reg;
        at_ext   = signed'({2'b0, atan_q30(5'(ccnt_reg))});

        case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    pop        = 1'b1;
                    theta_next = head.theta;
                    if (head.kind == KIND_WAYPOINT)
                    begin
                        state_next = ST_WAYPT;
                    end
                    else if (seg_open_reg)
                    begin
                        state_next = ST_PROD;
                    end
                end
            end
            ST_WAYPT:
            begin
                if (!have_pos_reg)
                begin
                    cur_angle_next  = theta_reg;
                    cur_radius_next = r_wp;
                    have_pos_next   = 1'b1;
                end
                else
                begin
                    dangle_next   = {theta_reg[31], theta_reg} - {cur_angle_reg[31], cur_angle_reg};
                    dradius_next  = signed'({1'b0, r_wp}) - signed'({1'b0, cur_radius_reg});
                    progress_next = '0;
                    seg_open_next = 1'b1;
                end
                state_next = ST_IDLE;
            end
            ST_PROD:
            begin
                state_next = ST_DIVR_SET;
            end
            ST_DIVR_SET:
            begin
                p_next = prod_reg[DW-1:0];
                f_next = ONE_Q20;
                if (dr_abs > RW'(1024))
                begin
                    rem_next   = DW'(1) << 10;
                    den_next   = DW'(dr_abs);
                    quo_next   = '0;
                    dcnt_next  = '0;
                    state_next = ST_DIVR;
                end
                else
                begin
                    state_next = ST_DIVA_SET;
                end
            end
            ST_DIVR, ST_DIVA:
            begin
                rem_next  = rem_step;
                quo_next  = quo_step;
                dcnt_next = dcnt_reg + 5'd1;
                if (dcnt_reg == 5'd19)
                begin
                    f_next     = f_min;
                    state_next = (state_reg == ST_DIVR) ? ST_DIVA_SET : ST_FIX;
                end
            end
            ST_DIVA_SET:
            begin
                if (p_reg > (DW'(1) << 30))
                begin
                    rem_next   = DW'(1) << 30;
                    den_next   = p_reg;
                    quo_next   = '0;
                    dcnt_next  = '0;
                    state_next = ST_DIVA;
                end
                else
                begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX:
            begin
                if (prog_sum > {1'b0, ONE_Q20})
                begin
                    f_next = ONE_Q20 - progress_reg;
                end
                else
                begin
                    f_next = f_nz;
                end
                state_next = ST_MOV_A;
            end
            ST_MOV_A:
            begin
                state_next = ST_MOV_R;
            end
            ST_MOV_R:
            begin
                cur_angle_next = dangle_reg[32] ? (cur_angle_reg - signed'(amag[31:0]))
                                                : (cur_angle_reg + signed'(amag[31:0]));
                state_next     = ST_MOV_FIN;
            end
            ST_MOV_FIN:
            begin
                if (rsum < 0)
                begin
                    cur_radius_next = '0;
                end
                else if (rsum[RW])
                begin
                    cur_radius_next = {RW{1'b1}};
                end
                else
                begin
                    cur_radius_next = rsum[RW-1:0];
                end
                progress_next = prog_new[20:0];
                last_next     = (prog_new >= {1'b0, ONE_Q20});
                if (prog_new >= {1'b0, ONE_Q20})
                begin
                    seg_open_next = 1'b0;
                end
                state_next = ST_PH1;
            end
            ST_PH1:
            begin
                state_next = ST_PH2;
            end
            ST_PH2:
            begin
                phase_next = cur_angle_reg[31] ? (prod_reg[51:20] - (PHASE_K << 12))
                                               : prod_reg[51:20];
                state_next = ST_PH3;
            end
            ST_PH3:
            begin
                state_next = ST_CR_INIT;
            end
            ST_CR_INIT:
            begin
                cz_next    = signed'({3'b0, prod_reg[60:30]});
                cx_next    = CORDIC_GAIN;
                cy_next    = '0;
                ccnt_next  = '0;
                state_next = ST_CR;
            end
            ST_CR:
            begin
                if (!cz_reg[33])
                begin
                    cx_next = cx_reg - shx;
                    cy_next = cy_reg + shy;
                    cz_next = cz_reg - at_ext;
                end
                else
                begin
                    cx_next = cx_reg + shx;
                    cy_next = cy_reg - shy;
                    cz_next = cz_reg + at_ext;
                end
                ccnt_next = ccnt_reg + CW'(1);
                if (ccnt_reg == CW'(CORDIC_STEPS - 1))
                begin
                    state_next = ST_ROT;
                end
            end
            ST_ROT:
            begin
                case (phase_reg[31:30])
                    2'd0:
                    begin
                        cos_next = cx_reg;
                        sin_next = cy_reg;
                    end
                    2'd1:
                    begin
                        cos_next = -cy_reg;
                        sin_next = cx_reg;
                    end
                    2'd2:
                    begin
                        cos_next = -cx_reg;
                        sin_next = -cy_reg;
                    end
                    default:
                    begin
                        cos_next = cy_reg;
                        sin_next = -cx_reg;
                    end
                endcase
                state_next = ST_OUT_X;
            end
            ST_OUT_X:
            begin
                state_next = ST_OUT_Y;
            end
            ST_OUT_Y:
            begin
                xo_next    = place(cos_reg[33], prod_reg, radius);
                state_next = ST_OUT_W;
            end
            ST_OUT_W:
            begin
                yo_next    = place(sin_reg[33], prod_reg, radius);
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_x_next     = xo_reg;
                    out_y_next     = yo_reg;
                    out_last_next  = last_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        theta_reg <= theta_next;
        prod_reg  <= prod_next;
        p_reg     <= p_next;
        rem_reg   <= rem_next;
        den_reg   <= den_next;
        quo_reg   <= quo_next;
        dcnt_reg  <= dcnt_next;
        f_reg     <= f_next;
        last_reg  <= last_next;
        phase_reg <= phase_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        cz_reg    <= cz_next;
        ccnt_reg  <= ccnt_next;
        cos_reg   <= cos_next;
        sin_reg   <= sin_next;
        xo_reg    <= xo_next;
        yo_reg    <= yo_next;
        out_x_reg <= out_x_next;
        out_y_reg <= out_y_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cur_angle_reg  <= '0;
            cur_radius_reg <= '0;
            dangle_reg     <= '0;
            dradius_reg    <= '0;
            progress_reg   <= '0;
            have_pos_reg   <= 1'b0;
            seg_open_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_angle_reg  <= cur_angle_next;
            cur_radius_reg <= cur_radius_next;
            dangle_reg     <= dangle_next;
            dradius_reg    <= dradius_next;
            progress_reg   <= progress_next;
            have_pos_reg   <= have_pos_next;
            seg_open_reg   <= seg_open_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    a_seg_has_pos: assert property (@(posedge clk) disable iff (!rst_n)
        seg_open_reg |-> have_pos_reg)
        else $error("segment open without a start position");

    a_progress_bound: assert property (@(posedge clk) disable iff (!rst_n)
        progress_reg <= ONE_Q20)
        else $error("progress passed one");

    a_factor_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MOV_A) |->
            (f_reg != '0) && (({1'b0, progress_reg} + {1'b0, f_reg}) <= {1'b0, ONE_Q20}))
        else $error("step factor is zero or overshoots the segment");

    a_send_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEND) && (!out_valid_reg || m_axis_tready) |=> out_valid_reg)
        else $error("finished step did not reach the output register");

endmodule

// ----- rtl/core/polar_path_interpolator.sv -----
// Top level of the polar path interpolator: radius register, front queue and back
// sequencer. Depends on ppi_pkg, ppi_front and ppi_back.
//
//   channel   direction  signals                                   contents
//   s_axis    in         tvalid tready tdata[55:0] tuser           theta, rho / mode
//   m_axis    out        tvalid tready tdata[47:0] tlast           x_pos, y_pos / last
//   cfg       in         cfg_we cfg_wdata[9:0]                     table_radius
//
// A waypoint passes through ST_WAYPT; a step with no open segment is popped and dropped.
// A step needs at most two divisions in the bit-serial divider and then runs the
// one-iteration-per-cycle CORDIC loop.
// The input queue holds four words, so input is taken while the back end is busy.
// Reset clears the queue, the path state and the output register; the radius resets to 300.
// A stalled output holds its word and the back end waits before loading the next one.
module polar_path_interpolator
    import ppi_pkg::*;
#(
    parameter int CORDIC_STEPS = 20,
    parameter int RADIUS_BITS  = 10
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [TDATA_IN_W-1:0]  s_axis_tdata,   // theta[31:0], rho[49:32], zero fill
    input  logic                   s_axis_tuser,   // mode
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [TDATA_OUT_W-1:0] m_axis_tdata,   // x_pos[20:0], y_pos[41:21], zero fill
    output logic                   m_axis_tlast,   // segment_last
    input  logic                   cfg_we,
    input  logic [CFG_W-1:0]       cfg_wdata
);

    logic [RADIUS_BITS-1:0] radius_reg, radius_next;
    ppi_item_t              head;
    logic                   head_valid;
    logic                   pop;

    assign radius_next = cfg_we ? RADIUS_BITS'(cfg_wdata) : radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_BITS'(10'd300);
        end
        else
        begin
            radius_reg <= radius_next;
        end
    end

    ppi_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .pop           (pop),
        .head          (head),
        .head_valid    (head_valid)
    );

    ppi_back #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .RADIUS_BITS  (RADIUS_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .radius        (radius_reg),
        .head          (head),
        .head_valid    (head_valid),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ----- tb/polar_path_interpolator_test.sv -----
// Testbench for polar_path_interpolator: drives waypoints and step requests, predicts every
// cartesian step word in fixed point and checks each output word against it.
// Depends on ppi_pkg and the polar_path_interpolator RTL.
module polar_path_interpolator_test;
    import ppi_pkg::*;

    typedef struct {
        ppi_kind_t          kind;
        logic signed [31:0] theta;
        logic [17:0]        rho;
    } waypoint_word_t;

    typedef struct {
        logic [20:0] x;
        logic [20:0] y;
        logic        last;
    } step_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [TDATA_IN_W-1:0] s_axis_tdata = '0;
    logic s_axis_tuser = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_axis_tdata;
    logic m_axis_tlast;
    logic cfg_we = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    polar_path_interpolator u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always #5 clk = ~clk;

    waypoint_word_t pending_words[$];
    step_word_t     expected_steps[$];
    waypoint_word_t word_on_bus;
    int             send_gap = 0;
    int             hold_left = 0;
    int             words_seen = 0;
    int             errors = 0;

    longint unsigned table_radius = 300;
    longint          pos_angle = 0;
    longint          pos_radius = 0;
    longint          seg_angle = 0;
    longint          seg_radius = 0;
    longint unsigned seg_progress = 0;
    bit              have_position = 0;
    bit              segment_open = 0;
    longint          gen_theta = 0;

    longint atan_table[20] = '{843314857, 497837829, 263043837, 133525159, 67021687,
        33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048};

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint scale_round(longint a, longint unsigned b, int s);
        longint unsigned m;
        longint unsigned p;
        m = (a < 0) ? longint'(-a) : longint'(a);
        p = (m * b + (64'd1 << (s - 1))) >> s;
        return (a < 0) ? -longint'(p) : longint'(p);
    endfunction

    task automatic predict_step(waypoint_word_t w);
        longint r, rho, c, s, x, y, z, dx, dy, base;
        longint unsigned f, dr, da, p, prod, rest;
        logic signed [31:0] wrapped;
        logic [31:0] phase;
        step_word_t e;
        if (w.kind == KIND_WAYPOINT) begin
            rho = clamp(longint'($signed(w.rho)), 0, 65536);
            r = (rho * longint'(table_radius)) >>> 6;
            if (!have_position) begin
                pos_angle = longint'(w.theta);
                pos_radius = r;
                have_position = 1;
            end
            else begin
                seg_angle = longint'(w.theta) - pos_angle;
                seg_radius = r - pos_radius;
                seg_progress = 0;
                segment_open = 1;
            end
            return;
        end
        if (!segment_open)
            return;
        f = 64'd1 << 20;
        dr = seg_radius < 0 ? -seg_radius : seg_radius;
        da = seg_angle < 0 ? -seg_angle : seg_angle;
        p = da * longint'(pos_radius);
        if (dr != 0 && (64'd1 << 30) / dr < f)
            f = (64'd1 << 30) / dr;
        if (p != 0 && (64'd1 << 50) / p < f)
            f = (64'd1 << 50) / p;
        if (f == 0)
            f = 1;
        if (seg_progress + f > (64'd1 << 20))
            f = (64'd1 << 20) - seg_progress;
        wrapped = 32'(pos_angle + scale_round(seg_angle, f, 20));
        pos_angle = longint'(wrapped);
        pos_radius = clamp(pos_radius + scale_round(seg_radius, f, 20), 0, (64'sd1 << 20) - 1);
        seg_progress += f;
        e.last = seg_progress >= (64'd1 << 20);
        if (e.last)
            segment_open = 0;
        prod = longint'(pos_angle) * 64'd683565276;
        phase = prod[51:20];
        rest = {34'd0, phase[29:0]};
        z = longint'((rest * 64'd1686629713) >> 30);
        x = 652032874;
        y = 0;
        for (int i = 0; i < 20; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin x -= dx; y += dy; z -= atan_table[i]; end
            else begin x += dx; y -= dy; z += atan_table[i]; end
        end
        case (phase[31:30])
            2'd0:    begin c = x;  s = y;  end
            2'd1:    begin c = -y; s = x;  end
            2'd2:    begin c = -x; s = -y; end
            default: begin c = y;  s = -x; end
        endcase
        base = longint'(table_radius << 10);
        e.x = 21'(clamp(base + scale_round(c, pos_radius, 30), 0, (64'sd1 << 21) - 1));
        e.y = 21'(clamp(base + scale_round(s, pos_radius, 30), 0, (64'sd1 << 21) - 1));
        expected_steps.insert(expected_steps.size(), e);
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
        end
        else begin
            if (s_axis_tvalid && s_axis_tready)
                predict_step(word_on_bus);
            if ((s_axis_tvalid && s_axis_tready) || !s_axis_tvalid) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_words.size() != 0) begin
                    word_on_bus = pending_words.pop_front();
                    s_axis_tdata <= {6'd0, word_on_bus.rho, word_on_bus.theta};
                    s_axis_tuser <= word_on_bus.kind;
                    s_axis_tvalid <= 1'b1;
                    send_gap <= $urandom_range(0, 1) ? 0 : $urandom_range(0, 19);
                end
                else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
        end
        else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_steps.size() == 0) begin
                    report_mismatch("unexpected word", m_axis_tdata[20:0], -1);
                end
                else begin
                    step_word_t e;
                    e = expected_steps.pop_front();
                    if (m_axis_tdata[20:0] !== e.x)
                        report_mismatch("x_pos", m_axis_tdata[20:0], e.x);
                    if (m_axis_tdata[41:21] !== e.y)
                        report_mismatch("y_pos", m_axis_tdata[41:21], e.y);
                    if (m_axis_tlast !== e.last)
                        report_mismatch("segment_last", m_axis_tlast, e.last);
                end
                words_seen++;
                if (words_seen == 100)
                    hold_left = 500;
                else
                    hold_left = $urandom_range(0, 1) ? 0 : $urandom_range(0, 19);
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic add_word(ppi_kind_t k, logic signed [31:0] th, logic [17:0] rh);
        waypoint_word_t w;
        w.kind = k;
        w.theta = th;
        w.rho = rh;
        pending_words.insert(pending_words.size(), w);
    endtask

    task automatic add_random(int count);
        int n;
        int shift;
        longint d;
        n = 0;
        while (n < count) begin
            if ($urandom_range(0, 9) != 0) begin
                shift = $urandom_range(4, 26);
                d = longint'($urandom & ((32'd1 << shift) - 1)) - (64'sd1 << (shift - 1));
                gen_theta = longint'(32'(gen_theta + d));
                add_word(KIND_WAYPOINT, 32'(gen_theta),
                    $urandom_range(0, 7) == 0 ? 18'($urandom) : 18'($urandom_range(0, 65536)));
                n++;
                repeat ($urandom_range(1, 8)) begin
                    add_word(KIND_STEP, 32'($urandom), 18'($urandom));
                    n++;
                end
            end
            else begin
                add_word($urandom_range(0, 1) ? KIND_STEP : KIND_WAYPOINT,
                    32'($urandom), 18'($urandom));
                n++;
            end
        end
    endtask

    task automatic write_radius(logic [CFG_W-1:0] v);
        while (pending_words.size() != 0 || s_axis_tvalid || expected_steps.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        table_radius = v;
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        write_radius(10'd300);
        add_word(KIND_STEP, 32'sd0, 18'd0);
        add_word(KIND_WAYPOINT, 32'sd0, 18'd65536);
        add_word(KIND_STEP, 32'sd0, 18'd0);
        add_word(KIND_WAYPOINT, 32'sh7FFFFFFF, 18'h1FFFF);
        repeat (3) add_word(KIND_STEP, 32'sh7FFFFFFF, 18'h3FFFF);
        add_word(KIND_WAYPOINT, 32'sh80000000, 18'h20000);
        repeat (2) add_word(KIND_STEP, 32'sd0, 18'd0);
        add_word(KIND_WAYPOINT, 32'sd1000, 18'd32768);
        repeat (4) add_word(KIND_STEP, 32'sd0, 18'd0);
        add_word(KIND_WAYPOINT, 32'sd2000, 18'd65536);
        repeat (6) add_word(KIND_STEP, 32'sd0, 18'd0);
        add_random(400);
        write_radius(10'd1);
        add_random(400);
        write_radius(10'd1023);
        add_random(450);
        write_radius(10'($urandom_range(1, 1023)));
        add_random(350);
        write_radius(10'd512);
        add_random(330);
        while (pending_words.size() != 0 || s_axis_tvalid || expected_steps.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0 && expected_steps.size() == 0)
            $display("[polar_path_interpolator] OK");
        else
            $display("[polar_path_interpolator] ERROR");
        $finish;
    end

    initial begin
        #40000000;
        $display("[polar_path_interpolator] ERROR");
        $finish;
    end

endmodule
